// ===== rtl/avfd_pkg.sv =====
`timescale 1ns / 1ps
package avfd_pkg;

	localparam int AXIS_W          = 16;
	localparam int SQ_W            = 32;
	localparam int MAG_W           = 15;
	localparam int VAR_W           = 30;
	localparam int THR_W           = 31;
	localparam int HOLD_W          = 8;
	localparam int CFG_IDX_W       = 1;
	localparam int IN_DATA_W       = 48;
	localparam int OUT_DATA_W      = 64;
	localparam int WINDOW_SIZE_DEF = 5;

	localparam logic [THR_W-1:0]  THRESHOLD_RESET = THR_W'(5000000);
	localparam logic [HOLD_W-1:0] HOLD_RESET      = HOLD_W'(15);
	localparam logic [MAG_W-1:0]  MAG_MAX         = MAG_W'(32767);
	localparam logic [SQ_W-1:0]   SUMSQ_SAT       = SQ_W'(1) << (2 * MAG_W);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESHOLD = 1'b0,
		REG_HOLD      = 1'b1
	} cfg_reg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SQUARE,
		S_ROOT_GO,
		S_ROOT,
		S_SUM,
		S_MEAN_GO,
		S_MEAN,
		S_VAR,
		S_VAR_GO,
		S_VAR_DIV,
		S_DONE
	} avfd_state_t;

endpackage

// ===== rtl/avfd_sqr.sv =====
`timescale 1ns / 1ps
module avfd_sqr
	import avfd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [AXIS_W-1:0] a,
	output logic              done,
	output logic [SQ_W-1:0]   sq
);

	localparam int CNT_W = $clog2(AXIS_W + 1);

	logic [AXIS_W-1:0] mag_in;
	logic [AXIS_W-1:0] mplr_q;
	logic [SQ_W-1:0]   mcand_q;
	logic [SQ_W-1:0]   acc_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	assign mag_in = a[AXIS_W-1] ? AXIS_W'(-a) : a;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(AXIS_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one multiplier bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			mplr_q  <= mag_in;
			mcand_q <= SQ_W'(mag_in);
			acc_q   <= '0;
		end else if (busy_q) begin
			if (mplr_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q <= {mcand_q[SQ_W-2:0], 1'b0};
			mplr_q  <= {1'b0, mplr_q[AXIS_W-1:1]};
		end
	end

	assign done = done_q;
	assign sq   = acc_q;

endmodule

// ===== rtl/avfd_isqrt.sv =====
`timescale 1ns / 1ps
module avfd_isqrt
	import avfd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [2*MAG_W-1:0] n,
	output logic               done,
	output logic [MAG_W-1:0]   root
);

	localparam int REM_W = MAG_W + 2;
	localparam int X_W   = REM_W + 2;
	localparam int CNT_W = $clog2(MAG_W + 1);

	logic [2*MAG_W-1:0] n_q;
	logic [REM_W-1:0]   rem_q;
	logic [MAG_W-1:0]   root_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [X_W-1:0]     remx;
	logic [X_W-1:0]     trial;
	logic               ge;

	// bring in two bits of the radicand, try root bit one
	always_comb begin
		remx  = {rem_q, n_q[2*MAG_W-1 -: 2]};
		trial = {2'b00, root_q, 2'b01};
		ge    = remx >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(MAG_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q    <= n;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			n_q    <= {n_q[2*MAG_W-3:0], 2'b00};
			rem_q  <= ge ? REM_W'(remx - trial) : REM_W'(remx);
			root_q <= {root_q[MAG_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ===== rtl/avfd_cdiv.sv =====
`timescale 1ns / 1ps
module avfd_cdiv
	import avfd_pkg::*;
#(
	parameter int NUM_W   = 33,
	parameter int DIVISOR = WINDOW_SIZE_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	output logic             done,
	output logic [NUM_W-1:0] quo
);

	localparam int REM_W = $clog2(DIVISOR) + 1;
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] work_q;
	logic [REM_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [REM_W-1:0] trial;
	logic             ge;

	always_comb begin
		trial = {rem_q[REM_W-2:0], work_q[NUM_W-1]};
		ge    = trial >= REM_W'(DIVISOR);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift the dividend out at the top, the quotient in at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= num;
			rem_q  <= '0;
		end else if (busy_q) begin
			work_q <= {work_q[NUM_W-2:0], ge};
			rem_q  <= ge ? REM_W'(trial - REM_W'(DIVISOR)) : trial;
		end
	end

	assign done = done_q;
	assign quo  = work_q;

endmodule

// ===== rtl/accel_variance_fall_detector.sv =====
`timescale 1ns / 1ps
// A new item is taken only once the result of the last one sits in the output register.
// The squarers, the root and the divider by WINDOW_SIZE are bit-serial; the divider (one
// quotient bit a cycle) is shared, used for both the mean and the variance.
// Reset clears the ring, write position, fall state and hold count, and loads the
// register defaults; there is no clearing pass.
module accel_variance_fall_detector
	import avfd_pkg::*;
#(
	parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// accel_x [15:0], accel_y [31:16], accel_z [47:32]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// magnitude [14:0], window_mean [29:15], window_variance [59:30],
	// falling [60], fall_alarm [61], zero [63:62]
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [THR_W-1:0]      cfg_data
);

	localparam int IDX_W = $clog2(WINDOW_SIZE);
	localparam int CNT_W = $clog2(WINDOW_SIZE + 2);
	localparam int SUM_W = MAG_W + $clog2(WINDOW_SIZE);
	localparam int ACC_W = 2 * MAG_W + $clog2(WINDOW_SIZE);

	avfd_state_t state_q, state_d;

	logic [THR_W-1:0]  thr_q;
	logic [HOLD_W-1:0] hold_ticks_q;
	logic [MAG_W-1:0]  ring_q [WINDOW_SIZE];
	logic [IDX_W-1:0]  pos_q;
	logic              fall_flag_q;
	logic [HOLD_W-1:0] hold_cnt_q;

	logic              accept;
	logic              sqx_done, sqy_done, sqz_done;
	logic [SQ_W-1:0]   sqx, sqy, sqz;
	logic [SQ_W-1:0]   sumsq_q;
	logic              sat;
	logic              root_start, root_done;
	logic [MAG_W-1:0]  root;
	logic              ring_we;
	logic [MAG_W-1:0]  ring_wdata;
	logic [MAG_W-1:0]  mag_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [MAG_W-1:0]  rd_entry;
	logic [SUM_W-1:0]  sum_q;
	logic              div_start, div_done;
	logic [ACC_W-1:0]  div_num, quo;
	logic [MAG_W-1:0]  mean_q;
	logic [MAG_W-1:0]  d_s1;
	logic              v_s1;
	logic [2*MAG_W-1:0] prod_s2;
	logic              v_s2;
	logic [ACC_W-1:0]  acc_q;
	logic [ACC_W-1:0]  var_q;
	logic              load_out;
	logic              out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	logic              fall_now;
	logic [HOLD_W-1:0] hold_inc;
	logic              flag_next;
	logic [HOLD_W-1:0] hold_next;
	logic              alarm;

	assign s_tready = state_q == S_IDLE;
	assign accept   = s_tvalid && s_tready;
	assign sat      = sumsq_q >= SUMSQ_SAT;

	avfd_sqr u_sqr_x (
		.clk(clk), .arst_n(arst_n), .start(accept),
		.a(s_tdata[AXIS_W-1:0]), .done(sqx_done), .sq(sqx)
	);

	avfd_sqr u_sqr_y (
		.clk(clk), .arst_n(arst_n), .start(accept),
		.a(s_tdata[2*AXIS_W-1:AXIS_W]), .done(sqy_done), .sq(sqy)
	);

	avfd_sqr u_sqr_z (
		.clk(clk), .arst_n(arst_n), .start(accept),
		.a(s_tdata[3*AXIS_W-1:2*AXIS_W]), .done(sqz_done), .sq(sqz)
	);

	avfd_isqrt u_isqrt (
		.clk(clk), .arst_n(arst_n), .start(root_start),
		.n(sumsq_q[2*MAG_W-1:0]), .done(root_done), .root(root)
	);

	avfd_cdiv #(
		.NUM_W(ACC_W),
		.DIVISOR(WINDOW_SIZE)
	) u_cdiv (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(div_num), .done(div_done), .quo(quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		root_start = 1'b0;
		ring_we    = 1'b0;
		ring_wdata = sat ? MAG_MAX : root;
		div_start  = 1'b0;
		div_num    = acc_q;
		load_out   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_SQUARE;
				end
			end
			S_SQUARE: begin
				if (sqx_done) begin
					state_d = S_ROOT_GO;
				end
			end
			S_ROOT_GO: begin
				if (sat) begin
					ring_we = 1'b1;
					state_d = S_SUM;
				end else begin
					root_start = 1'b1;
					state_d    = S_ROOT;
				end
			end
			S_ROOT: begin
				if (root_done) begin
					ring_we = 1'b1;
					state_d = S_SUM;
				end
			end
			S_SUM: begin
				if (cnt_q == CNT_W'(WINDOW_SIZE - 1)) begin
					state_d = S_MEAN_GO;
				end
			end
			S_MEAN_GO: begin
				div_start = 1'b1;
				div_num   = ACC_W'(sum_q);
				state_d   = S_MEAN;
			end
			S_MEAN: begin
				if (div_done) begin
					state_d = S_VAR;
				end
			end
			S_VAR: begin
				if (cnt_q == CNT_W'(WINDOW_SIZE + 1)) begin
					state_d = S_VAR_GO;
				end
			end
			S_VAR_GO: begin
				div_start = 1'b1;
				state_d   = S_VAR_DIV;
			end
			S_VAR_DIV: begin
				if (div_done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q        <= THRESHOLD_RESET;
			hold_ticks_q <= HOLD_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_THRESHOLD: thr_q        <= cfg_data;
				REG_HOLD:      hold_ticks_q <= cfg_data[HOLD_W-1:0];
				default:       ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_SIZE; i++) begin
				ring_q[i] <= '0;
			end
			pos_q <= '0;
		end else if (ring_we) begin
			ring_q[pos_q] <= ring_wdata;
			pos_q <= (pos_q == IDX_W'(WINDOW_SIZE - 1)) ? '0 : pos_q + IDX_W'(1);
		end
	end

	assign rd_entry = (cnt_q < CNT_W'(WINDOW_SIZE)) ? ring_q[cnt_q[IDX_W-1:0]] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
		end else begin
			cnt_q <= (state_q == S_SUM || state_q == S_VAR) ? cnt_q + CNT_W'(1) : '0;
			v_s1  <= state_q == S_VAR && cnt_q < CNT_W'(WINDOW_SIZE);
			v_s2  <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_SQUARE && sqx_done) begin
			sumsq_q <= sqx + sqy + sqz;
		end
		if (ring_we) begin
			mag_q <= ring_wdata;
		end
		if (state_q == S_ROOT_GO || state_q == S_ROOT) begin
			sum_q <= '0;
		end else if (state_q == S_SUM) begin
			sum_q <= sum_q + SUM_W'(rd_entry);
		end
		if (state_q == S_MEAN && div_done) begin
			mean_q <= quo[MAG_W-1:0];
		end
		d_s1    <= (rd_entry >= mean_q) ? rd_entry - mean_q : mean_q - rd_entry;
		prod_s2 <= (2*MAG_W)'(d_s1) * (2*MAG_W)'(d_s1);
		if (state_q == S_MEAN) begin
			acc_q <= '0;
		end else if (state_q == S_VAR && v_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
		if (state_q == S_VAR_DIV && div_done) begin
			var_q <= quo;
		end
	end

	always_comb begin
		fall_now  = fall_flag_q || (var_q > ACC_W'(thr_q));
		hold_inc  = hold_cnt_q + HOLD_W'(1);
		flag_next = 1'b0;
		hold_next = hold_cnt_q;
		alarm     = 1'b0;
		if (fall_now) begin
			alarm     = hold_cnt_q == '0;
			flag_next = 1'b1;
			hold_next = hold_inc;
			if (hold_inc >= hold_ticks_q) begin
				flag_next = 1'b0;
				hold_next = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fall_flag_q <= 1'b0;
			hold_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				fall_flag_q <= flag_next;
				hold_cnt_q  <= hold_next;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= {2'b00, alarm, flag_next, var_q[VAR_W-1:0], mean_q, mag_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(sqx_done == sqy_done) && (sqx_done == sqz_done))
		else $error("squarer lanes out of step");

	a_hold_matches_flag: assert property (@(posedge clk) disable iff (!arst_n)
		fall_flag_q == (hold_cnt_q != '0))
		else $error("hold count and fall state disagree");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == S_DONE))
		else $error("result raised outside the finishing step");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_SQUARE && !sqx_done)
		else $error("item taken while a previous one is in flight");

endmodule
